### hdl/lew_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor package
// Shared types, key codes and result codes of the word-wrapping line editor.
// ----------------------------------------------------------------------------
package lew_pkg;

  // Default screen line width
  localparam int LINE_WIDTH_DEF = 40;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int ACT_W  = 3;
  localparam int CNT_W  = 6;

  // Key codes
  localparam logic [CHAR_W-1:0] KEY_EOT      = 8'd4;
  localparam logic [CHAR_W-1:0] KEY_BS       = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_LF       = 8'd10;
  localparam logic [CHAR_W-1:0] KEY_KILL     = 8'd21;
  localparam logic [CHAR_W-1:0] KEY_WERASE   = 8'd23;
  localparam logic [CHAR_W-1:0] KEY_SPACE    = 8'd32;
  localparam logic [CHAR_W-1:0] KEY_TILDE    = 8'd126;
  localparam logic [CHAR_W-1:0] KEY_DEL      = 8'd127;

  // Terminal action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ECHO    = 3'd0,
    ACT_ERASE   = 3'd1,
    ACT_NEWLINE = 3'd2,
    ACT_BELL    = 3'd3,
    ACT_END     = 3'd4
  } action_t;

  // One result beat
  typedef struct packed {
    action_t           action;
    logic [CHAR_W-1:0] out_char;
    logic [CNT_W-1:0]  erase_count;
    logic              last;
  } result_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic    valid;
    result_t res;
  } emit_t;

endpackage

### hdl/lew_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor channels
// Valid/ready channels for keystroke bytes and terminal action beats.
// ----------------------------------------------------------------------------
interface lew_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface lew_act_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] out_char;
  logic [5:0] erase_count;
  logic       last;

  modport source (output valid, output action, output out_char, output erase_count,
                  output last, input ready);
  modport sink (input valid, input action, input out_char, input erase_count,
                input last, output ready);
endinterface

### hdl/line_editor_word_wrap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor with word wrap
// Usage:
//   in_ch carries one keystroke byte per beat; out_ch carries terminal action
//   beats (echo, erase, newline, bell, end of input), with last set on the
//   final beat caused by a keystroke. Some keystrokes cause no beat at all.
//   One keystroke is in work at a time; in_ch.ready is high only when idle.
//   Simple keys load their beat into the result register from the decode
//   state and reopen the input with it; the decode state waits while the
//   output register is busy. Word erase scans the line buffer one entry at
//   a time (a read state, then a check state), and a wrap at full width
//   scans the trailing word the same way, then moves and echoes it one
//   character at a time (a read state, then a write state), all through
//   the single read port of the line buffer. A single output register holds
//   the next beat; while the receiver stalls the sequencer waits at that
//   beat and nothing is lost. Reset empties the line and clears the
//   end-of-input flag; the buffer contents need no clearing since only
//   entries below the length are read.
// ----------------------------------------------------------------------------
module line_editor_word_wrap_top
  import lew_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lew_char_if.sink   in_ch,
  lew_act_if.source  out_ch
);

  localparam int AW = $clog2(LINE_WIDTH);

  emit_t             emit;
  logic              slot_free;
  logic              in_ready;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  assign in_ch.ready = in_ready;

  lew_seq #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_char   (in_ch.in_char),
    .in_ready  (in_ready),
    .slot_free (slot_free),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lew_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lew_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // A beat is issued only into a free output register
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> slot_free)
    else $error("result issued while output register busy");

  // Nothing is issued while waiting for a keystroke
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !emit.valid)
    else $error("result issued while idle");

  // The input is closed in the cycle after a keystroke is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("input reopened right after accept");

  // Only echo beats carry a character
  a_char_only_echo: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.action != ACT_ECHO) |-> (out_ch.out_char == '0))
    else $error("character on a non-echo beat");
`endif

endmodule

### hdl/lew_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lew_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/lew_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor output register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module lew_out_reg
  import lew_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  emit_t            emit,
  output logic             slot_free,
  lew_act_if.source        out_ch
);

  logic    valid;
  result_t data;

  assign slot_free = !valid || out_ch.ready;

  // Load a new beat, or drop the one taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (emit.valid) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  // Payload carries no reset
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      data <= emit.res;
    end
  end

  assign out_ch.valid       = valid;
  assign out_ch.action      = data.action;
  assign out_ch.out_char    = data.out_char;
  assign out_ch.erase_count = data.erase_count;
  assign out_ch.last        = data.last;

endmodule

### hdl/lew_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor sequencer
// Decodes each keystroke and walks the line buffer one entry at a time for
// word erase, the wrap scan and the word move, issuing result beats.
// ----------------------------------------------------------------------------
module lew_seq
  import lew_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF,
  localparam int LEN_W = $clog2(LINE_WIDTH + 1),
  localparam int AW = $clog2(LINE_WIDTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_char,
  output logic              in_ready,
  input  logic              slot_free,
  output emit_t             emit,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [CHAR_W-1:0] ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [CHAR_W-1:0] ram_rdata
);

  localparam logic [LEN_W-1:0] FULL = LEN_W'(LINE_WIDTH);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_DECODE     = 10'b00_0000_0010,
    S_RD         = 10'b00_0000_0100,
    S_CHK        = 10'b00_0000_1000,
    S_ERASE_W    = 10'b00_0001_0000,
    S_WRAP_ERASE = 10'b00_0010_0000,
    S_WRAP_NL    = 10'b00_0100_0000,
    S_MV_RD      = 10'b00_1000_0000,
    S_MV_WR      = 10'b01_0000_0000,
    S_ECHO_C     = 10'b10_0000_0000
  } state_t;

  state_t            state, state_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [LEN_W-1:0]  pos, pos_next;
  logic [LEN_W-1:0]  j, j_next;
  logic [CHAR_W-1:0] ch;
  logic              phase, phase_next;
  logic              wrap_mode, wrap_mode_next;
  logic              finished, finished_next;

  logic [LEN_W-1:0]  word_len;
  logic [LEN_W-1:0]  pos_dec;
  logic [LEN_W-1:0]  mv_src;
  logic [LEN_W-1:0]  j_inc;
  logic [LEN_W-1:0]  pos_after;
  logic              is_space;
  logic              printable;
  logic              scan_stop;

  assign in_ready  = (state == S_IDLE);
  assign word_len  = len - pos;
  assign pos_dec   = pos - 1'b1;
  assign mv_src    = pos + j;
  assign j_inc     = j + 1'b1;
  assign is_space  = (ram_rdata == KEY_SPACE);
  assign printable = (ch >= KEY_SPACE) && (ch <= KEY_TILDE);

  // Scan step: drop trailing spaces first (word erase only), then the non-space run
  assign scan_stop = phase && is_space;
  assign pos_after = scan_stop ? pos : pos_dec;

  // Read address: scan looks below pos, move reads the word in place
  assign ram_raddr = (state == S_MV_RD || state == S_MV_WR) ? mv_src[AW-1:0]
                                                             : pos_dec[AW-1:0];

  always_comb begin
    state_next     = state;
    len_next       = len;
    pos_next       = pos;
    j_next         = j;
    phase_next     = phase;
    wrap_mode_next = wrap_mode;
    finished_next  = finished;
    emit           = '0;
    ram_we         = 1'b0;
    ram_waddr      = len[AW-1:0];
    ram_wdata      = ch;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end

      // Handle the single-beat keys, or start a scan
      S_DECODE: begin
        if (slot_free) begin
          state_next = S_IDLE;
          priority if (finished) begin
            state_next = S_IDLE;
          end else if (ch == KEY_EOT && len == '0) begin
            finished_next        = 1'b1;
            emit.valid           = 1'b1;
            emit.res.action      = ACT_END;
            emit.res.last        = 1'b1;
          end else if (ch == KEY_LF) begin
            len_next             = '0;
            emit.valid           = 1'b1;
            emit.res.action      = ACT_NEWLINE;
            emit.res.last        = 1'b1;
          end else if (ch == KEY_DEL || ch == KEY_BS) begin
            if (len != '0) begin
              len_next             = len - 1'b1;
              emit.valid           = 1'b1;
              emit.res.action      = ACT_ERASE;
              emit.res.erase_count = CNT_W'(1);
              emit.res.last        = 1'b1;
            end
          end else if (ch == KEY_KILL) begin
            if (len != '0) begin
              len_next             = '0;
              emit.valid           = 1'b1;
              emit.res.action      = ACT_ERASE;
              emit.res.erase_count = CNT_W'(len);
              emit.res.last        = 1'b1;
            end
          end else if (ch == KEY_WERASE) begin
            if (len != '0) begin
              pos_next       = len;
              phase_next     = 1'b0;
              wrap_mode_next = 1'b0;
              state_next     = S_RD;
            end
          end else if (printable) begin
            if (len != FULL) begin
              ram_we            = 1'b1;
              len_next          = len + 1'b1;
              emit.valid        = 1'b1;
              emit.res.action   = ACT_ECHO;
              emit.res.out_char = ch;
              emit.res.last     = 1'b1;
            end else begin
              pos_next       = len;
              phase_next     = 1'b1;
              wrap_mode_next = 1'b1;
              state_next     = S_RD;
            end
          end else begin
            emit.valid      = 1'b1;
            emit.res.action = ACT_BELL;
            emit.res.last   = 1'b1;
          end
        end
      end

      // Read address is out, data lands next cycle
      S_RD: begin
        state_next = S_CHK;
      end

      // Examine one buffer entry and step down
      S_CHK: begin
        pos_next = pos_after;
        if (!phase) begin
          phase_next = !is_space;
        end
        if (scan_stop || pos_after == '0) begin
          if (wrap_mode) begin
            state_next = S_WRAP_ERASE;
          end else if (pos_after != len) begin
            state_next = S_ERASE_W;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_RD;
        end
      end

      S_ERASE_W: begin
        if (slot_free) begin
          emit.valid           = 1'b1;
          emit.res.action      = ACT_ERASE;
          emit.res.erase_count = CNT_W'(word_len);
          emit.res.last        = 1'b1;
          len_next             = pos;
          state_next           = S_IDLE;
        end
      end

      // Erase the trailing word, or the whole line if the word fills it
      S_WRAP_ERASE: begin
        if (slot_free) begin
          if (pos == '0) begin
            emit.valid           = 1'b1;
            emit.res.action      = ACT_ERASE;
            emit.res.erase_count = CNT_W'(len);
            emit.res.last        = 1'b1;
            len_next             = '0;
            state_next           = S_IDLE;
          end else begin
            if (word_len != '0) begin
              emit.valid           = 1'b1;
              emit.res.action      = ACT_ERASE;
              emit.res.erase_count = CNT_W'(word_len);
            end
            j_next     = '0;
            state_next = S_WRAP_NL;
          end
        end
      end

      S_WRAP_NL: begin
        if (slot_free) begin
          emit.valid      = 1'b1;
          emit.res.action = ACT_NEWLINE;
          state_next      = (word_len == '0) ? S_ECHO_C : S_MV_RD;
        end
      end

      S_MV_RD: begin
        state_next = S_MV_WR;
      end

      // Move one word character to the line head and echo it
      S_MV_WR: begin
        if (slot_free) begin
          ram_we            = 1'b1;
          ram_waddr         = j[AW-1:0];
          ram_wdata         = ram_rdata;
          emit.valid        = 1'b1;
          emit.res.action   = ACT_ECHO;
          emit.res.out_char = ram_rdata;
          j_next            = j_inc;
          state_next        = (j_inc == word_len) ? S_ECHO_C : S_MV_RD;
        end
      end

      // Append the new character after the moved word
      S_ECHO_C: begin
        if (slot_free) begin
          ram_we            = 1'b1;
          ram_waddr         = word_len[AW-1:0];
          emit.valid        = 1'b1;
          emit.res.action   = ACT_ECHO;
          emit.res.out_char = ch;
          emit.res.last     = 1'b1;
          len_next          = word_len + 1'b1;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      finished  <= 1'b0;
      pos       <= '0;
      j         <= '0;
      phase     <= 1'b0;
      wrap_mode <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      finished  <= finished_next;
      pos       <= pos_next;
      j         <= j_next;
      phase     <= phase_next;
      wrap_mode <= wrap_mode_next;
    end
  end

  // Capture the keystroke on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch <= in_char;
    end
  end

endmodule
